[rtl/cif_pkg.sv]
// ----------------------------------------------------------------------------
// cif_pkg
// Shared types, constants and arithmetic helpers of the 3x3 image filter.
// ----------------------------------------------------------------------------
package cif_pkg;

    typedef enum logic [2:0] {
        MODE_IDENT  = 3'd0,
        MODE_EDGE   = 3'd1,
        MODE_SHARP  = 3'd2,
        MODE_BLUR   = 3'd3,
        MODE_GAUSS  = 3'd4,
        MODE_EMBOSS = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_CHANS  = 2'd2,
        REG_MODE   = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        STEP_PIXEL = 2'd0,
        STEP_VIRT  = 2'd1,
        STEP_VIRT2 = 2'd2
    } t_step;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTRW  = 2;
    localparam int Q_LVLW  = 3;

    // floor(t/9) as (t * BLUR_RECIP) >> BLUR_SHIFT, exact for t < 32768
    localparam int BLUR_RECIP = 3641;
    localparam int BLUR_SHIFT = 15;

    // window of nine packed pixels plus edge and frame-last flags of the output position
    typedef struct packed {
        logic [8:0][31:0] win;
        logic             left;
        logic             right;
        logic             top;
        logic             bot;
        logic             last;
    } t_job;

    typedef struct packed {
        logic [Q_LVLW-1:0] level;
        logic              empty;
        logic              full;
    } t_qstat;

    function automatic logic signed [13:0] conv_sum(t_mode m, logic [8:0][7:0] s);
        logic signed [13:0] p [9];
        logic signed [13:0] tot;
        logic signed [13:0] res;
        tot = '0;
        for (int k = 0; k < 9; k++) begin
            p[k] = signed'(14'(s[k]));
            tot  = tot + p[k];
        end
        case (m)
            MODE_EDGE:   res = (p[4] <<< 3) + p[4] - tot;
            MODE_SHARP:  res = (p[4] <<< 2) + p[4] - p[1] - p[3] - p[5] - p[7];
            MODE_BLUR:   res = tot;
            MODE_GAUSS:  res = p[0] + p[2] + p[6] + p[8]
                             + ((p[1] + p[3] + p[5] + p[7]) <<< 1) + (p[4] <<< 2);
            MODE_EMBOSS: res = p[4] + p[5] + p[7] - p[1] - p[3]
                             + ((p[8] - p[0]) <<< 1);
            default:     res = p[4];
        endcase
        return res;
    endfunction

    function automatic logic [7:0] finish(t_mode m, logic signed [13:0] s);
        logic signed [14:0] v;
        logic        [12:0] t;
        logic        [25:0] prod;
        t    = s[13] ? '0 : 13'(s + 14'sd4);
        prod = 26'(t) * 26'(BLUR_RECIP);
        case (m)
            MODE_BLUR:   v = signed'(15'(prod >> BLUR_SHIFT));
            MODE_GAUSS:  v = s[13] ? '0 : ((15'(s) + 15'sd8) >>> 4);
            MODE_EMBOSS: v = 15'(s) + 15'sd128;
            default:     v = 15'(s);
        endcase
        if (v < 0) begin
            return 8'd0;
        end else if (v > 15'sd255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

endpackage

[rtl/cif_front.sv]
// ----------------------------------------------------------------------------
// cif_front
// Position tracking, line store and 3x3 window. Emits one window job for
// each beat that produces an output pixel.
// ----------------------------------------------------------------------------
module cif_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int CW = $clog2(MAX_WIDTH),
    parameter int WW = $clog2(MAX_WIDTH + 1),
    parameter int HW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic [WW-1:0]              i_w,
    input  logic [HW-1:0]              i_h,
    input  logic                       i_accept,
    input  logic [31:0]                i_pixel,
    input  logic                       i_drain,
    input  cif_pkg::t_qstat            i_qstat,
    output logic                       o_ready,
    output logic                       o_push,
    output cif_pkg::t_job              o_job
);

    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int QLW = cif_pkg::Q_LVLW;

    logic [63:0] r_line [MAX_WIDTH];     // {upper row, middle row}
    logic [63:0] r_rd_a, r_rd_b, r_fwd_d;
    logic        r_fwd_a, r_fwd_b;

    logic [CW-1:0] r_in_col, n_in_col;
    logic [RW-1:0] r_in_row, n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [HW-1:0] r_out_row, n_out_row;

    logic              r_s1_v;
    cif_pkg::t_step    r_s1_kind;
    logic [CW-1:0]     r_s1_col;
    logic [31:0]       r_s1_px;
    logic              r_s1_emit, r_s1_left, r_s1_right, r_s1_top, r_s1_bot, r_s1_last;
    logic [8:0][31:0]  r_win, n_win;

    logic [CW-1:0]  col1, col2;
    logic [RW-1:0]  row1, row2;
    logic           wrap0, wrap1, due0, due1, in_frame;
    logic           step_v, emit, last;
    cif_pkg::t_step kind;

    logic        s1_wr;
    logic [31:0] ua, ma, ub, mb;
    logic [63:0] wr_data;
    logic [2:0][31:0] col_a, col_b;

    assign o_ready = i_qstat.level <= QLW'(cif_pkg::Q_DEPTH - 2);

    // two column advances, the second only used past the frame
    always_comb begin
        wrap0 = (WW'(r_in_col) + 1'b1) >= i_w;
        col1  = wrap0 ? '0 : r_in_col + 1'b1;
        row1  = wrap0 ? r_in_row + 1'b1 : r_in_row;
        wrap1 = (WW'(col1) + 1'b1) >= i_w;
        col2  = wrap1 ? '0 : col1 + 1'b1;
        row2  = wrap1 ? row1 + 1'b1 : row1;
        due0  = (r_in_row >= RW'(2)) || (r_in_row == RW'(1) && r_in_col != '0);
        due1  = (row1 >= RW'(2)) || (row1 == RW'(1) && col1 != '0);
        in_frame = r_in_row < RW'(i_h);
        last  = ((WW'(r_out_col) + 1'b1) >= i_w) && ((r_out_row + 1'b1) >= i_h);
    end

    always_comb begin
        step_v   = 1'b0;
        emit     = 1'b0;
        kind     = cif_pkg::STEP_PIXEL;
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        if (i_accept) begin
            if (in_frame) begin
                if (!i_drain) begin
                    step_v   = 1'b1;
                    emit     = due0;
                    n_in_col = col1;
                    n_in_row = row1;
                end
            end else if (due0) begin
                step_v   = 1'b1;
                kind     = cif_pkg::STEP_VIRT;
                emit     = 1'b1;
                n_in_col = col1;
                n_in_row = row1;
            end else begin
                // single-row frame: one silent step before the first output
                step_v   = 1'b1;
                kind     = cif_pkg::STEP_VIRT2;
                emit     = due1;
                n_in_col = col2;
                n_in_row = row2;
            end
        end
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (emit) begin
            if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if ((WW'(r_out_col) + 1'b1) >= i_w) begin
                n_out_col = '0;
                n_out_row = r_out_row + 1'b1;
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_s1_v    <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_s1_v    <= step_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_kind  <= kind;
        r_s1_col   <= r_in_col;
        r_s1_px    <= i_pixel;
        r_s1_emit  <= emit;
        r_s1_left  <= r_out_col == '0;
        r_s1_right <= (WW'(r_out_col) + 1'b1) >= i_w;
        r_s1_top   <= r_out_row == '0;
        r_s1_bot   <= (r_out_row + 1'b1) >= i_h;
        r_s1_last  <= last;
        r_win      <= n_win;
    end

    // line store: read at both candidate columns, write back in stage 1
    assign s1_wr = r_s1_v && (r_s1_kind == cif_pkg::STEP_PIXEL);

    always_ff @(posedge i_clk) begin
        r_rd_a <= r_line[r_in_col];
        r_rd_b <= r_line[col1];
        if (s1_wr) begin
            r_line[r_s1_col] <= wr_data;
        end
    end

    // a read issued on the edge of a write to the same column sees old data
    always_ff @(posedge i_clk) begin
        r_fwd_a <= s1_wr && (r_s1_col == r_in_col);
        r_fwd_b <= s1_wr && (r_s1_col == col1);
        r_fwd_d <= wr_data;
    end

    always_comb begin
        ua = r_fwd_a ? r_fwd_d[63:32] : r_rd_a[63:32];
        ma = r_fwd_a ? r_fwd_d[31:0]  : r_rd_a[31:0];
        ub = r_fwd_b ? r_fwd_d[63:32] : r_rd_b[63:32];
        mb = r_fwd_b ? r_fwd_d[31:0]  : r_rd_b[31:0];
        wr_data = {ma, r_s1_px};
        col_a[0] = ua;
        col_a[1] = ma;
        col_a[2] = (r_s1_kind == cif_pkg::STEP_PIXEL) ? r_s1_px : ma;
        col_b[0] = ub;
        col_b[1] = mb;
        col_b[2] = mb;
        n_win = r_win;
        if (r_s1_v) begin
            for (int r = 0; r < 3; r++) begin
                if (r_s1_kind == cif_pkg::STEP_VIRT2) begin
                    n_win[r*3]   = r_win[r*3+2];
                    n_win[r*3+1] = col_a[r];
                    n_win[r*3+2] = col_b[r];
                end else begin
                    n_win[r*3]   = r_win[r*3+1];
                    n_win[r*3+1] = r_win[r*3+2];
                    n_win[r*3+2] = col_a[r];
                end
            end
        end
    end

    assign o_push      = r_s1_v && r_s1_emit;
    assign o_job.win   = n_win;
    assign o_job.left  = r_s1_left;
    assign o_job.right = r_s1_right;
    assign o_job.top   = r_s1_top;
    assign o_job.bot   = r_s1_bot;
    assign o_job.last  = r_s1_last;

endmodule

[rtl/cif_queue.sv]
// ----------------------------------------------------------------------------
// cif_queue
// Short FIFO of window jobs between the front and the back.
// ----------------------------------------------------------------------------
module cif_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cif_pkg::t_job   i_din,
    input  logic            i_pop,
    output cif_pkg::t_job   o_head,
    output cif_pkg::t_qstat o_stat
);

    localparam int LW = cif_pkg::Q_LVLW;

    cif_pkg::t_job                 r_mem [cif_pkg::Q_DEPTH];
    logic [cif_pkg::Q_PTRW-1:0]    r_wp, r_rp;
    logic [LW-1:0]                 r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_level <= r_level + LW'(i_push) - LW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_din;
        end
    end

    assign o_head       = r_mem[r_rp];
    assign o_stat.level = r_level;
    assign o_stat.empty = r_level == '0;
    assign o_stat.full  = r_level == LW'(cif_pkg::Q_DEPTH);

endmodule

[rtl/cif_back.sv]
// ----------------------------------------------------------------------------
// cif_back
// Edge replication, kernel sums and rounding/clamp, with the output register.
// ----------------------------------------------------------------------------
module cif_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cif_pkg::t_mode  i_mode,
    input  logic [2:0]      i_nch,
    input  cif_pkg::t_job   i_job,
    input  cif_pkg::t_qstat i_qstat,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_data,
    output logic            o_last
);

    logic                      r_a_v, r_a_last;
    logic signed [3:0][13:0]   r_a_sum, n_a_sum;
    logic                      r_o_v, r_o_last;
    logic [31:0]               r_o_data, n_o_data;
    logic                      out_en, a_en;
    logic [1:0]                ri [3];
    logic [1:0]                ci [3];
    logic [8:0][7:0]           smp;

    assign out_en = !r_o_v || i_ready;
    assign a_en   = !r_a_v || out_en;
    assign o_pop  = !i_qstat.empty && a_en;

    always_comb begin
        ri[0] = i_job.top   ? 2'd1 : 2'd0;
        ri[1] = 2'd1;
        ri[2] = i_job.bot   ? 2'd1 : 2'd2;
        ci[0] = i_job.left  ? 2'd1 : 2'd0;
        ci[1] = 2'd1;
        ci[2] = i_job.right ? 2'd1 : 2'd2;
        smp   = '0;
        for (int ch = 0; ch < 4; ch++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    smp[i*3+j] = i_job.win[ri[i]*3 + ci[j]][ch*8 +: 8];
                end
            end
            n_a_sum[ch] = cif_pkg::conv_sum(i_mode, smp);
        end
    end

    always_comb begin
        for (int ch = 0; ch < 4; ch++) begin
            n_o_data[ch*8 +: 8] = (3'(ch) < i_nch) ?
                                  cif_pkg::finish(i_mode, r_a_sum[ch]) : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (a_en) begin
                r_a_v <= !i_qstat.empty;
            end
            if (out_en) begin
                r_o_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_sum  <= n_a_sum;
            r_a_last <= i_job.last;
        end
        if (out_en && r_a_v) begin
            r_o_data <= n_o_data;
            r_o_last <= r_a_last;
        end
    end

    assign o_valid = r_o_v;
    assign o_data  = r_o_data;
    assign o_last  = r_o_last;

endmodule

[rtl/conv3x3_image_filter_core.sv]
// ----------------------------------------------------------------------------
// conv3x3_image_filter_core
// Streaming 3x3 convolution filter with replicated borders.
// ----------------------------------------------------------------------------
// Takes one beat per clock in raster order while tready is high and gives
// one output beat per clock while the master side does not stall. An output
// pixel reaches the master side through line store read and window update,
// job queue write, kernel sum and round/clamp; the line store is read and
// written once per beat, so beats may follow back to back.
// tready drops while more than two jobs wait in the queue, i.e. only when
// the master side stalls. Outputs trail input by one row plus one pixel;
// after the last pixel of a frame send drain beats (tuser=1) to flush the
// rest; tlast marks the frame's final output. Any register write restarts
// the frame. The line store needs no clearing after reset.
module conv3x3_image_filter_core #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_HEIGHT   = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // chan_a, chan_b, chan_c, chan_d
    input  logic        s_axis_tuser,   // drain
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // res_a, res_b, res_c, res_d
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [11:0] r_cfg_w, r_cfg_h;
    logic [2:0]  r_cfg_nch, r_cfg_mode;
    logic        cfg_wr;
    cif_pkg::t_reg reg_sel;

    logic [WW-1:0]   eff_w;
    logic [HW-1:0]   eff_h;
    logic [2:0]      eff_nch;
    cif_pkg::t_mode  eff_mode;

    logic            accept, push, pop;
    cif_pkg::t_job   job_in, job_head;
    cif_pkg::t_qstat qstat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = cif_pkg::t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= 12'd1;
            r_cfg_h    <= 12'd1;
            r_cfg_nch  <= 3'd1;
            r_cfg_mode <= 3'd0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                cif_pkg::REG_WIDTH:  r_cfg_w    <= pwdata[11:0];
                cif_pkg::REG_HEIGHT: r_cfg_h    <= pwdata[11:0];
                cif_pkg::REG_CHANS:  r_cfg_nch  <= pwdata[2:0];
                cif_pkg::REG_MODE:   r_cfg_mode <= pwdata[2:0];
                default:             r_cfg_w    <= r_cfg_w;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            cif_pkg::REG_WIDTH:  prdata = 32'(r_cfg_w);
            cif_pkg::REG_HEIGHT: prdata = 32'(r_cfg_h);
            cif_pkg::REG_CHANS:  prdata = 32'(r_cfg_nch);
            cif_pkg::REG_MODE:   prdata = 32'(r_cfg_mode);
            default:             prdata = '0;
        endcase
    end

    // zero acts as 1, oversize saturates; an unknown mode falls back to identity
    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            eff_h = HW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_cfg_h);
        end
        if (r_cfg_nch == '0) begin
            eff_nch = 3'd1;
        end else if (32'(r_cfg_nch) > MAX_CHANNELS) begin
            eff_nch = 3'(MAX_CHANNELS);
        end else begin
            eff_nch = r_cfg_nch;
        end
        eff_mode = (r_cfg_mode > 3'd5) ? cif_pkg::MODE_IDENT : cif_pkg::t_mode'(r_cfg_mode);
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    cif_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .WW         (WW),
        .HW         (HW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cfg_wr),
        .i_w      (eff_w),
        .i_h      (eff_h),
        .i_accept (accept),
        .i_pixel  (s_axis_tdata),
        .i_drain  (s_axis_tuser),
        .i_qstat  (qstat),
        .o_ready  (s_axis_tready),
        .o_push   (push),
        .o_job    (job_in)
    );

    cif_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (job_in),
        .i_pop   (pop),
        .o_head  (job_head),
        .o_stat  (qstat)
    );

    cif_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (eff_mode),
        .i_nch   (eff_nch),
        .i_job   (job_head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && qstat.full && !pop))
        else $error("job queue overflow");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pop && qstat.empty))
        else $error("job queue underflow");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && qstat.empty)
        else $error("output not idle after reset");

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench of the 3x3 image filter core.
// ----------------------------------------------------------------------------
// Frames of random or constant pixels stream in over the slave side with
// random gaps while the master side stalls at random. A line-store model in
// the testbench forms the same windows, applies each kernel with edge
// replication, rounding, bias and clamping, and checks every output beat
// against the oldest pending prediction. Registers are rewritten between
// frames only while the core is idle.
module tb;

    localparam int MAXW = 2048;
    localparam int MAXH = 2048;
    localparam int MAXC = 4;

    typedef struct packed {
        logic [31:0] pix;
        logic        tlast;
    } t_outbeat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // chan_a, chan_b, chan_c, chan_d
    logic        s_axis_tuser = 1'b0; // drain
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // res_a, res_b, res_c, res_d
    logic        m_axis_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    conv3x3_image_filter_core u_dut (.*);

    always #2 i_clk = ~i_clk;

    // model state
    logic [31:0] upper_line [MAXW];
    logic [31:0] middle_line [MAXW];
    logic [31:0] win [9];
    int unsigned in_col, in_row, out_col, out_row;
    logic [11:0] cfg_width = 12'd1, cfg_height = 12'd1;
    logic [2:0]  cfg_chans = 3'd1, cfg_mode = 3'd0;

    t_outbeat pending_pix [$];
    bit  failed = 1'b0;
    bit  calm = 1'b0;     // no random idling
    int  no_stall = 0;
    string res_name [4] = '{"res_a", "res_b", "res_c", "res_d"};

    function automatic int unsigned clip(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return v > hi ? hi : v;
    endfunction

    function automatic int tap(cif_pkg::t_mode m, int k);
        int edge_k [9] = '{-1, -1, -1, -1, 8, -1, -1, -1, -1};
        int sharp_k [9] = '{0, -1, 0, -1, 5, -1, 0, -1, 0};
        int gauss_k [9] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
        int emb_k [9] = '{-2, -1, 0, -1, 1, 1, 0, 1, 2};
        case (m)
            cif_pkg::MODE_EDGE:   return edge_k[k];
            cif_pkg::MODE_SHARP:  return sharp_k[k];
            cif_pkg::MODE_BLUR:   return 1;
            cif_pkg::MODE_GAUSS:  return gauss_k[k];
            cif_pkg::MODE_EMBOSS: return emb_k[k];
            default:              return k == 4 ? 1 : 0;
        endcase
    endfunction

    function automatic void slide(logic [31:0] t, logic [31:0] m, logic [31:0] b);
        logic [31:0] col [3];
        col[0] = t; col[1] = m; col[2] = b;
        for (int r = 0; r < 3; r++) begin
            win[r*3] = win[r*3+1];
            win[r*3+1] = win[r*3+2];
            win[r*3+2] = col[r];
        end
    endfunction

    function automatic void filter_pixel();
        int unsigned w, h, nch;
        cif_pkg::t_mode md;
        int cols [3], rows [3];
        int s, v, dv;
        t_outbeat ob;
        w = clip(cfg_width, MAXW);
        h = clip(cfg_height, MAXH);
        nch = clip(cfg_chans, MAXC);
        md = cfg_mode > 3'd5 ? cif_pkg::MODE_IDENT : cif_pkg::t_mode'(cfg_mode);
        dv = md == cif_pkg::MODE_BLUR ? 9 : (md == cif_pkg::MODE_GAUSS ? 16 : 1);
        cols[0] = out_col == 0 ? 1 : 0; cols[1] = 1;
        cols[2] = out_col + 1 >= w ? 1 : 2;
        rows[0] = out_row == 0 ? 1 : 0; rows[1] = 1;
        rows[2] = out_row + 1 >= h ? 1 : 2;
        ob.pix = '0;
        for (int ch = 0; ch < 4; ch++) begin
            if (ch < nch) begin
                s = 0;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        s += tap(md, i*3+j) * int'(win[rows[i]*3+cols[j]][8*ch +: 8]);
                if (dv == 1) v = s + (md == cif_pkg::MODE_EMBOSS ? 128 : 0);
                else v = s < 0 ? 0 : (2*s + dv) / (2*dv);
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                ob.pix[8*ch +: 8] = v[7:0];
            end
        end
        ob.tlast = (out_col + 1 >= w) && (out_row + 1 >= h);
        pending_pix.push_back(ob);
        if (ob.tlast) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    function automatic bit step_due();
        return in_row >= 2 || (in_row == 1 && in_col >= 1);
    endfunction

    function automatic void advance(int unsigned w);
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
    endfunction

    function automatic void predict_beat(logic [31:0] px, logic drain);
        int unsigned w, h, c;
        logic [31:0] t, m;
        bit due;
        w = clip(cfg_width, MAXW);
        h = clip(cfg_height, MAXH);
        if (in_row < h) begin
            if (drain) return;
            c = in_col < MAXW ? in_col : 0;
            t = upper_line[c];
            m = middle_line[c];
            upper_line[c] = m;
            middle_line[c] = px;
            slide(t, m, px);
            due = step_due();
            advance(w);
            if (due) filter_pixel();
            return;
        end
        for (int k = 0; k < 2; k++) begin
            c = in_col < MAXW ? in_col : 0;
            slide(upper_line[c], middle_line[c], middle_line[c]);
            due = step_due();
            advance(w);
            if (due) begin
                filter_pixel();
                return;
            end
        end
    endfunction

    // tvalid stays high after a beat; idle gaps and wait_idle drop it
    task automatic send_beat(logic [31:0] px, logic drain);
        while (!calm && $urandom_range(99) < 9) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        s_axis_tuser <= drain;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_beat(px, drain);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (pending_pix.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(cif_pkg::t_reg idx, logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 4'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            cif_pkg::REG_WIDTH:  cfg_width = val[11:0];
            cif_pkg::REG_HEIGHT: cfg_height = val[11:0];
            cif_pkg::REG_CHANS:  cfg_chans = val[2:0];
            default:             cfg_mode = val[2:0];
        endcase
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        pending_pix.delete();
        @(posedge i_clk);
    endtask

    task automatic setup(int w, int h, int ch, int md);
        wait_idle();
        write_reg(cif_pkg::REG_WIDTH, w);
        write_reg(cif_pkg::REG_HEIGHT, h);
        write_reg(cif_pkg::REG_CHANS, ch);
        write_reg(cif_pkg::REG_MODE, md);
    endtask

    // one frame of pixels then drains until the frame's last beat is predicted
    task automatic run_frame(int kind);
        int unsigned w, h;
        logic [31:0] px;
        w = clip(cfg_width, MAXW);
        h = clip(cfg_height, MAXH);
        for (int n = 0; n < w*h; n++) begin
            case (kind)
                0: px = 32'h0;
                1: px = 32'hFFFF_FFFF;
                2: px = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'h0;
                default: px = $urandom;
            endcase
            if (kind == 3 && $urandom_range(49) == 0) send_beat($urandom, 1'b1);
            send_beat(px, 1'b0);
        end
        // pixels after frame end act as drains
        while (in_row != 0 || in_col != 0)
            send_beat($urandom, 1'($urandom_range(1)));
    endtask

    task automatic test_directed();
        int m;
        setup(1, 1, 4, cif_pkg::MODE_IDENT);
        run_frame(3);
        setup(3, 3, 4, cif_pkg::MODE_EDGE);
        run_frame(2);
        for (m = 0; m < 8; m++) begin
            setup(2, 2, m == 7 ? 0 : (m % 4) + 1, m);
            run_frame(m % 2);
            run_frame(2);
        end
        // zero width and height
        setup(0, 0, 7, cif_pkg::MODE_SHARP);
        run_frame(3);
    endtask

    task automatic test_modes();
        for (int md = 0; md < 6; md++) begin
            setup($urandom_range(1, 7), $urandom_range(1, 5), $urandom_range(1, 4), md);
            run_frame(3);
            run_frame(2);
        end
    endtask

    task automatic test_random();
        int total;
        total = 0;
        while (total < 700) begin
            setup($urandom_range(1, 9), $urandom_range(1, 8), $urandom_range(0, 7),
                  $urandom_range(0, 7));
            calm = ($urandom_range(5) == 0);
            total += clip(cfg_width, MAXW) * clip(cfg_height, MAXH);
            run_frame($urandom_range(9) < 8 ? 3 : 2);
        end
        calm = 1'b0;
    endtask

    task automatic test_wide();
        setup(40, 3, 4, cif_pkg::MODE_GAUSS);
        run_frame(3);
        setup(33, 1, 2, cif_pkg::MODE_EMBOSS);
        run_frame(3);
    endtask

    // output side: random stalls except in a long quiet stretch
    always @(posedge i_clk) begin
        if (no_stall > 0) no_stall <= no_stall - 1;
        else if ($urandom_range(999) == 0) no_stall <= 600;
        m_axis_tready <= (no_stall > 0) || ($urandom_range(99) >= 9);
    end

    always @(posedge i_clk) begin
        t_outbeat ob;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_pix.size() == 0) begin
                $error("unexpected beat: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
                failed = 1'b1;
            end else begin
                ob = pending_pix.pop_front();
                for (int ch = 0; ch < 4; ch++)
                    if (m_axis_tdata[8*ch +: 8] !== ob.pix[8*ch +: 8]) begin
                        $error("%s: expected %0d, got %0d", res_name[ch],
                               ob.pix[8*ch +: 8], m_axis_tdata[8*ch +: 8]);
                        failed = 1'b1;
                    end
                if (m_axis_tlast !== ob.tlast) begin
                    $error("frame_end: expected %b, got %b", ob.tlast, m_axis_tlast);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_modes();
        test_wide();
        test_random();
        wait_idle();
        if (pending_pix.size() != 0) failed = 1'b1;
        if (!failed) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
